// ===== design/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Shared wrappers for concurrent assertions clocked on the block clock.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked only outside reset.
`define TWM_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// Checked at every edge, reset included.
`define TWM_ASSERT_ALWAYS(label, prop, msg) \
   label: assert property (@(posedge clock) prop) else $error(msg);

`endif

// ===== design/twm_pkg.sv =====
// ----------------------------------------------------------------------------
// twm_pkg
// Types, codes and defaults shared by the two-way sorted merge block.
// ----------------------------------------------------------------------------
package twm_pkg;

   localparam int DEPTH_DEFAULT      = 32;
   localparam int DATA_WIDTH_DEFAULT = 32;

   // Input command codes.
   typedef enum logic [1:0] {
      CMD_ELEM_A = 2'd0,
      CMD_ELEM_B = 2'd1,
      CMD_END_A  = 2'd2,
      CMD_END_B  = 2'd3
   } cmd_type;

   // Result kinds.
   typedef enum logic [1:0] {
      KIND_ELEM = 2'd0,
      KIND_DONE = 2'd1,
      KIND_FULL = 2'd2,
      KIND_LATE = 2'd3
   } kind_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DECIDE,
      ST_MERGE,
      ST_DRAIN,
      ST_DONE
   } state_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic     capture;
      logic     push;
      logic     pop;
      logic     set_owner;
      logic     set_ended;
      logic     clear;
      logic     out_load;
      logic     out_sel_head;
      logic     out_last;
      kind_type out_kind;
   } ctl_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic is_end;
      logic mine_ended;
      logic other_ended;
      logic count_zero;
      logic count_one;
      logic full;
      logic owner_is_me;
      logic head_first;
      logic slot_free;
   } status_type;

endpackage

// ===== design/twm_if.sv =====
// ----------------------------------------------------------------------------
// twm_req_if / twm_rsp_if
// Valid/ready channels for input words and result words of the merge block.
// ----------------------------------------------------------------------------
interface twm_req_if #(
   parameter int DATA_WIDTH = twm_pkg::DATA_WIDTH_DEFAULT
);
   logic                         valid;
   logic                         ready;
   logic [1:0]                   cmd;
   logic signed [DATA_WIDTH-1:0] value;

   modport source (output valid, output cmd, output value, input ready);
   modport sink   (input valid, input cmd, input value, output ready);
endinterface

interface twm_rsp_if #(
   parameter int DATA_WIDTH = twm_pkg::DATA_WIDTH_DEFAULT
);
   logic                         valid;
   logic                         ready;
   logic signed [DATA_WIDTH-1:0] out_value;
   logic [1:0]                   kind;
   logic                         run_last;

   modport source (output valid, output out_value, output kind, output run_last,
                   input ready);
   modport sink   (input valid, input out_value, input kind, input run_last,
                   output ready);
endinterface

// ===== design/twm_ram.sv =====
// ----------------------------------------------------------------------------
// twm_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module twm_ram #(
   parameter int WIDTH = twm_pkg::DATA_WIDTH_DEFAULT,
   parameter int DEPTH = twm_pkg::DEPTH_DEFAULT,
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== design/twm_datapath.sv =====
// ----------------------------------------------------------------------------
// twm_datapath
// Holds the current input word, the backlog FIFO with its owner and the end
// flags, and the result register; reports status to the controller.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module twm_datapath #(
   parameter int DEPTH      = twm_pkg::DEPTH_DEFAULT,
   parameter int DATA_WIDTH = twm_pkg::DATA_WIDTH_DEFAULT
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic [1:0]                   req_cmd,
   input  logic signed [DATA_WIDTH-1:0] req_value,
   input  twm_pkg::ctl_type             ctl,
   output twm_pkg::status_type          status,
   input  logic                         rsp_ready,
   output logic                         rsp_valid,
   output logic signed [DATA_WIDTH-1:0] rsp_out_value,
   output logic [1:0]                   rsp_kind,
   output logic                         rsp_run_last
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   twm_pkg::cmd_type             cmd_ff, cmd_in;
   logic signed [DATA_WIDTH-1:0] value_ff, value_in;
   logic [CNT_W-1:0]             count_ff, count_in;
   logic [PTR_W-1:0]             rd_ptr_ff, rd_ptr_in;
   logic [PTR_W-1:0]             wr_ptr_ff, wr_ptr_in;
   logic                         owner_ff, owner_in;
   logic                         a_ended_ff, a_ended_in;
   logic                         b_ended_ff, b_ended_in;
   logic                         rsp_valid_ff, rsp_valid_in;
   logic signed [DATA_WIDTH-1:0] out_value_ff, out_value_in;
   twm_pkg::kind_type            kind_ff, kind_in;
   logic                         last_ff, last_in;

   logic                         me;
   logic signed [DATA_WIDTH-1:0] head;

   function automatic logic [PTR_W-1:0] next_ptr(input logic [PTR_W-1:0] p);
      next_ptr = (p == PTR_W'(DEPTH - 1)) ? '0 : p + PTR_W'(1);
   endfunction

   twm_ram #(
      .WIDTH (DATA_WIDTH),
      .DEPTH (DEPTH)
   ) u_backlog (
      .clock   (clock),
      .wr_en   (ctl.push),
      .wr_addr (wr_ptr_ff),
      .wr_data (value_ff),
      .rd_addr (rd_ptr_in),
      .rd_data (head)
   );

   assign me = (cmd_ff == twm_pkg::CMD_ELEM_B) || (cmd_ff == twm_pkg::CMD_END_B);

   always_comb begin
      status.is_end      = (cmd_ff == twm_pkg::CMD_END_A) || (cmd_ff == twm_pkg::CMD_END_B);
      status.mine_ended  = me ? b_ended_ff : a_ended_ff;
      status.other_ended = me ? a_ended_ff : b_ended_ff;
      status.count_zero  = (count_ff == '0);
      status.count_one   = (count_ff == CNT_W'(1));
      status.full        = (count_ff >= CNT_W'(DEPTH));
      status.owner_is_me = (owner_ff == me);
      // On a tie the word of stream B leaves first.
      status.head_first  = me ? (head < value_ff) : (head <= value_ff);
      status.slot_free   = !rsp_valid_ff || rsp_ready;
   end

   always_comb begin
      cmd_in   = ctl.capture ? twm_pkg::cmd_type'(req_cmd) : cmd_ff;
      value_in = ctl.capture ? req_value : value_ff;

      count_in  = count_ff;
      rd_ptr_in = rd_ptr_ff;
      wr_ptr_in = wr_ptr_ff;
      if (ctl.push && !ctl.pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (ctl.pop && !ctl.push) begin
         count_in = count_ff - CNT_W'(1);
      end
      if (ctl.pop) begin
         rd_ptr_in = next_ptr(rd_ptr_ff);
      end
      if (ctl.push) begin
         wr_ptr_in = next_ptr(wr_ptr_ff);
      end

      owner_in   = ctl.set_owner ? me : owner_ff;
      a_ended_in = a_ended_ff || (ctl.set_ended && !me);
      b_ended_in = b_ended_ff || (ctl.set_ended && me);

      if (ctl.clear) begin
         count_in   = '0;
         rd_ptr_in  = '0;
         wr_ptr_in  = '0;
         owner_in   = 1'b0;
         a_ended_in = 1'b0;
         b_ended_in = 1'b0;
      end
   end

   always_comb begin
      rsp_valid_in = ctl.out_load || (rsp_valid_ff && !rsp_ready);
      kind_in      = ctl.out_load ? ctl.out_kind : kind_ff;
      last_in      = ctl.out_load ? ctl.out_last : last_ff;
      out_value_in = out_value_ff;
      if (ctl.out_load) begin
         if (ctl.out_kind == twm_pkg::KIND_ELEM) begin
            out_value_in = ctl.out_sel_head ? head : value_ff;
         end else begin
            out_value_in = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rd_ptr_ff    <= '0;
         wr_ptr_ff    <= '0;
         owner_ff     <= 1'b0;
         a_ended_ff   <= 1'b0;
         b_ended_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         rd_ptr_ff    <= rd_ptr_in;
         wr_ptr_ff    <= wr_ptr_in;
         owner_ff     <= owner_in;
         a_ended_ff   <= a_ended_in;
         b_ended_ff   <= b_ended_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff       <= cmd_in;
      value_ff     <= value_in;
      out_value_ff <= out_value_in;
      kind_ff      <= kind_in;
      last_ff      <= last_in;
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_out_value = out_value_ff;
   assign rsp_kind      = kind_ff;
   assign rsp_run_last  = last_ff;

   `TWM_ASSERT(a_pop_nonempty, ctl.pop |-> (count_ff != '0),
               "pop from an empty backlog")
   `TWM_ASSERT(a_push_room, (ctl.push && !ctl.pop) |-> (count_ff < CNT_W'(DEPTH)),
               "push into a full backlog")
   `TWM_ASSERT(a_empty_ptrs, (count_ff == '0) |-> (rd_ptr_ff == wr_ptr_ff),
               "empty backlog with pointers apart")

endmodule

// ===== design/twm_controller.sv =====
// ----------------------------------------------------------------------------
// twm_controller
// Sequencer for the merge: decides each input word, then steps through merge,
// drain and completion, one result word per cycle while the slot is free.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module twm_controller (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  twm_pkg::status_type status,
   output twm_pkg::ctl_type    ctl
);

   twm_pkg::state_type state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         twm_pkg::ST_IDLE: begin
            if (req_valid) begin
               state_in = twm_pkg::ST_DECIDE;
            end
         end
         twm_pkg::ST_DECIDE: begin
            if (status.slot_free) begin
               state_in = twm_pkg::ST_IDLE;
               if (!status.mine_ended && !status.count_zero && !status.owner_is_me) begin
                  state_in = status.is_end ? twm_pkg::ST_DRAIN : twm_pkg::ST_MERGE;
               end
            end
         end
         twm_pkg::ST_MERGE: begin
            if (status.slot_free) begin
               if (!status.head_first) begin
                  state_in = twm_pkg::ST_IDLE;
               end else if (status.count_one) begin
                  state_in = twm_pkg::ST_DECIDE;
               end
            end
         end
         twm_pkg::ST_DRAIN: begin
            if (status.slot_free && status.count_one) begin
               state_in = status.other_ended ? twm_pkg::ST_DONE : twm_pkg::ST_IDLE;
            end
         end
         twm_pkg::ST_DONE: begin
            if (status.slot_free) begin
               state_in = twm_pkg::ST_IDLE;
            end
         end
         default: state_in = twm_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      ctl          = '0;
      ctl.out_kind = twm_pkg::KIND_ELEM;
      req_ready    = (state_ff == twm_pkg::ST_IDLE);
      unique case (state_ff)
         twm_pkg::ST_IDLE: begin
            ctl.capture = req_valid;
         end
         twm_pkg::ST_DECIDE: begin
            if (status.slot_free) begin
               if (status.mine_ended) begin
                  ctl.out_load = 1'b1;
                  ctl.out_kind = twm_pkg::KIND_LATE;
                  ctl.out_last = 1'b1;
               end else if (!status.is_end) begin
                  if (status.count_zero) begin
                     if (status.other_ended) begin
                        ctl.out_load = 1'b1;
                        ctl.out_last = 1'b1;
                     end else begin
                        ctl.push      = 1'b1;
                        ctl.set_owner = 1'b1;
                     end
                  end else if (status.owner_is_me) begin
                     if (status.full) begin
                        ctl.out_load = 1'b1;
                        ctl.out_kind = twm_pkg::KIND_FULL;
                        ctl.out_last = 1'b1;
                     end else begin
                        ctl.push = 1'b1;
                     end
                  end
               end else begin
                  ctl.set_ended = 1'b1;
                  if (status.count_zero && status.other_ended) begin
                     ctl.out_load = 1'b1;
                     ctl.out_kind = twm_pkg::KIND_DONE;
                     ctl.out_last = 1'b1;
                     ctl.clear    = 1'b1;
                  end
               end
            end
         end
         twm_pkg::ST_MERGE: begin
            if (status.slot_free) begin
               ctl.out_load = 1'b1;
               if (status.head_first) begin
                  ctl.out_sel_head = 1'b1;
                  ctl.pop          = 1'b1;
                  ctl.out_last     = status.count_one && !status.other_ended;
               end else begin
                  ctl.out_last = 1'b1;
               end
            end
         end
         twm_pkg::ST_DRAIN: begin
            if (status.slot_free) begin
               ctl.out_load     = 1'b1;
               ctl.out_sel_head = 1'b1;
               ctl.pop          = 1'b1;
               ctl.out_last     = status.count_one && !status.other_ended;
            end
         end
         twm_pkg::ST_DONE: begin
            if (status.slot_free) begin
               ctl.out_load = 1'b1;
               ctl.out_kind = twm_pkg::KIND_DONE;
               ctl.out_last = 1'b1;
               ctl.clear    = 1'b1;
            end
         end
         default: ctl = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= twm_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   `TWM_ASSERT(a_accept_decides, (req_valid && req_ready) |=> (state_ff == twm_pkg::ST_DECIDE), "accepted word not decided")
   `TWM_ASSERT(a_walk_nonempty, ((state_ff == twm_pkg::ST_MERGE) || (state_ff == twm_pkg::ST_DRAIN)) |-> !status.count_zero, "merge or drain with empty backlog")
   `TWM_ASSERT(a_load_has_slot, ctl.out_load |-> status.slot_free, "result loaded over a pending word")

endmodule

// ===== design/two_way_sorted_merge.sv =====
// ----------------------------------------------------------------------------
// two_way_sorted_merge: merge of two ascending signed streams through one FIFO
// An input word is accepted and then decided; a merge pops backlog words and
// then places the element, a drain pops backlog words and may end with a
// completion word. Every result word passes through the output register.
// Synchronous reset clears the sequencer, FIFO bookkeeping, end flags and the
// output valid flag at once; the backlog RAM itself is never cleared.
// ----------------------------------------------------------------------------
//
// Operation
//   The input channel carries element words of stream A or B and end words
//   that close a stream. While both streams are open, the stream that is
//   ahead keeps its elements in a single backlog FIFO, tagged with its owner.
//   An element of the other stream is compared with the FIFO head: smaller
//   heads are emitted one per cycle while the output is free, then the element
//   itself; if the FIFO runs empty, the element is pushed and its stream takes
//   ownership, or emitted if the other stream is closed. Ties emit B first.
//
//   Closing a stream drains the FIFO if the other stream owns it. When both
//   streams are closed and the FIFO is empty, a completion word is emitted and
//   the block returns to its reset state.
//
//   An element pushed into a full FIFO is dropped and reported, and a word
//   for a stream that is already closed is reported as late. run_last marks
//   the final result word caused by one input word; an input word may also
//   cause no result at all.
//
// Structure
//   twm_controller sequences each input word (decide, merge, drain, done);
//   twm_datapath holds the FIFO pointers, owner, end flags, the compare and
//   the output register. The output register lets the next input word be
//   accepted while a result word waits for rsp.ready. The throughput limit is
//   the single FIFO read port: one head word is compared and popped per cycle unless the output stalls.
// ----------------------------------------------------------------------------
module two_way_sorted_merge #(
   parameter int DEPTH      = twm_pkg::DEPTH_DEFAULT,
   parameter int DATA_WIDTH = twm_pkg::DATA_WIDTH_DEFAULT
) (
   input  logic clock,
   input  logic reset,
   twm_req_if.sink   req_ch,
   twm_rsp_if.source rsp_ch
);

   twm_pkg::ctl_type    ctl;
   twm_pkg::status_type status;

   // Sequencer: owns the input handshake and issues one command set per cycle.
   twm_controller u_controller (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_ready (req_ch.ready),
      .status    (status),
      .ctl       (ctl)
   );

   // Datapath: FIFO, stream bookkeeping, head compare and result register.
   twm_datapath #(
      .DEPTH      (DEPTH),
      .DATA_WIDTH (DATA_WIDTH)
   ) u_datapath (
      .clock         (clock),
      .reset         (reset),
      .req_cmd       (req_ch.cmd),
      .req_value     (req_ch.value),
      .ctl           (ctl),
      .status        (status),
      .rsp_ready     (rsp_ch.ready),
      .rsp_valid     (rsp_ch.valid),
      .rsp_out_value (rsp_ch.out_value),
      .rsp_kind      (rsp_ch.kind),
      .rsp_run_last  (rsp_ch.run_last)
   );

endmodule
